@@ rtl/core/mipmap_box_downsample_macros.svh @@
// assertion macros used by the mipmap downsampler rtl
`ifndef MIPMAP_BOX_DOWNSAMPLE_MACROS_SVH
`define MIPMAP_BOX_DOWNSAMPLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MBDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbds assertion failed");

// next-cycle implication, checked out of reset
`define MBDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbds assertion failed");

`endif

@@ rtl/core/mbds_pkg.sv @@
// shared constants and types for the mipmap box downsampler
`timescale 1ns / 1ps
package mbds_pkg;

    localparam int MAX_WIDTH_DEFAULT    = 4096;
    localparam int CHANNEL_BITS_DEFAULT = 16;
    localparam int HEIGHT_LIMIT         = 4096;
    localparam int DIM_RESET            = 4096;
    localparam int CFG_BITS             = 13;
    localparam int CFG_ADDR_BITS        = 1;
    localparam int NUM_CHANNELS         = 4;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SOURCE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SOURCE_HEIGHT = 1'd1;

    // control carried with a pixel from the input register to the result register
    typedef struct packed {
        logic       write;     // store pair sums in the line store
        logic       emit;      // produce a destination pixel
        logic       use_line;  // add the stored even-row pair sums
        logic       fwd;       // line data comes from the forward register
        logic [1:0] shift;     // log2 of the pixel count
        logic       last;      // last destination pixel of the level
    } t_s1_ctl;

endpackage

@@ rtl/core/mbds_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module mbds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mipmap_box_downsample.sv @@
// one mipmap level by 2x2 box filtering of a raster rgba pixel stream
`timescale 1ns / 1ps
`include "mipmap_box_downsample_macros.svh"

// Source pixels enter on the s_axis side in raster order, one per cycle. The pixel that
// completes a 2x2 block is accepted into an input stage, where its line-store read is
// issued; when that stage advances, its destination pixel is loaded into the result
// register and shown on the m_axis side. tlast marks the last destination pixel of the
// level. The block sustains one pixel per cycle: the input stalls only while the result
// register holds a transaction that m_axis_tready does not take and the input stage
// holds the next result. The line store holds (MAX_WIDTH+1)/2 pair sums per channel and
// needs no clearing after reset. Writing source_width or source_height restarts the
// frame; width 0 counts as 1, larger values saturate at MAX_WIDTH and 4096. An odd last
// column or row is consumed without output, unless that dimension is 1.
module mipmap_box_downsample #(
    parameter int MAX_WIDTH    = mbds_pkg::MAX_WIDTH_DEFAULT,
    parameter int CHANNEL_BITS = mbds_pkg::CHANNEL_BITS_DEFAULT,
    localparam int DATA_BITS   = ((mbds_pkg::NUM_CHANNELS * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mbds_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [mbds_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // in_red, in_green, in_blue, in_alpha from bit 0 up, zero padded
    input  logic [DATA_BITS-1:0]               i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha from bit 0 up, zero padded
    output logic [DATA_BITS-1:0]               o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    localparam int NCH        = mbds_pkg::NUM_CHANNELS;
    localparam int CB         = CHANNEL_BITS;
    localparam int PAIR_BITS  = CB + 1;
    localparam int SUM_BITS   = CB + 2;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int YW         = $clog2(mbds_pkg::HEIGHT_LIMIT);
    localparam int HW         = $clog2(mbds_pkg::HEIGHT_LIMIT + 1);
    localparam int CWW        = (WW > mbds_pkg::CFG_BITS) ? WW : mbds_pkg::CFG_BITS;
    localparam int CHW        = (HW > mbds_pkg::CFG_BITS) ? HW : mbds_pkg::CFG_BITS;
    localparam int W_RESET    = (mbds_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                  : mbds_pkg::DIM_RESET;
    localparam int H_RESET    = (mbds_pkg::DIM_RESET > mbds_pkg::HEIGHT_LIMIT)
                                ? mbds_pkg::HEIGHT_LIMIT : mbds_pkg::DIM_RESET;
    localparam int LINE_BITS  = NCH * PAIR_BITS;
    localparam int PIX_BITS   = NCH * CB;

    // configuration and position
    logic [WW-1:0] r_width,  n_width;
    logic [HW-1:0] r_height, n_height;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;

    // even-column pixel waiting for its right neighbor
    logic [PIX_BITS-1:0] r_held;

    // input stage
    logic                r_s1_valid;
    mbds_pkg::t_s1_ctl   r_s1_ctl, n_ctl;
    logic [PIX_BITS-1:0] r_s1_pix;
    logic [PIX_BITS-1:0] r_s1_left, n_left;
    logic [AW-1:0]       r_s1_idx, n_idx;
    logic [LINE_BITS-1:0] r_fwd_data;

    // result register
    logic                r_o_valid;
    logic [PIX_BITS-1:0] r_o_pix;
    logic                r_o_last;

    logic [CWW-1:0]      cfg_w_ext;
    logic [CHW-1:0]      cfg_h_ext;
    logic                accept, s1_advance, s1_ready;
    logic                hs, vs, x_odd, y_odd, x_last, y_last, have_pair;
    logic [XW-1:0]       dx;
    logic [YW-1:0]       dy;
    logic [WW-1:0]       wo_m1;
    logic [HW-1:0]       ho_m1;
    logic [LINE_BITS-1:0] s1_pair_packed, line_rdata, line_data;
    logic [PIX_BITS-1:0] s1_result;
    logic                line_we;

    // configuration clamp: zero counts as one, saturate at the limits
    always_comb begin
        cfg_w_ext = CWW'(i_cfg_data);
        cfg_h_ext = CHW'(i_cfg_data);
        if (cfg_w_ext == '0) begin
            n_width = WW'(1);
        end else if (cfg_w_ext > CWW'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = WW'(cfg_w_ext);
        end
        if (cfg_h_ext == '0) begin
            n_height = HW'(1);
        end else if (cfg_h_ext > CHW'(mbds_pkg::HEIGHT_LIMIT)) begin
            n_height = HW'(mbds_pkg::HEIGHT_LIMIT);
        end else begin
            n_height = HW'(cfg_h_ext);
        end
    end

    // handshake
    assign s1_advance      = !r_s1_ctl.emit || !r_o_valid || i_m_axis_tready;
    assign s1_ready        = !r_s1_valid || s1_advance;
    assign o_s_axis_tready = s1_ready;
    assign accept          = i_s_axis_tvalid && s1_ready;

    // position decode for the incoming pixel
    always_comb begin
        hs        = r_width > WW'(1);
        vs        = r_height > HW'(1);
        x_odd     = r_col[0];
        y_odd     = r_row[0];
        x_last    = (WW'(r_col) + WW'(1)) == r_width;
        y_last    = (HW'(r_row) + HW'(1)) == r_height;
        have_pair = !hs || x_odd;
        dx        = hs ? (r_col >> 1) : r_col;
        dy        = vs ? (r_row >> 1) : r_row;
        wo_m1     = hs ? ((r_width >> 1) - WW'(1)) : '0;
        ho_m1     = vs ? ((r_height >> 1) - HW'(1)) : '0;
        n_idx     = dx[AW-1:0];

        n_ctl.write    = have_pair && vs && !y_odd && !y_last;
        n_ctl.emit     = have_pair && (!vs || y_odd);
        n_ctl.use_line = vs && y_odd;
        n_ctl.shift    = {1'b0, hs} + {1'b0, vs && y_odd};
        n_ctl.last     = (WW'(dx) == wo_m1) && (HW'(dy) == ho_m1);
        // line entry still being written by the pixel ahead of this one
        n_ctl.fwd      = r_s1_valid && r_s1_ctl.write && (r_s1_idx == n_idx);
        n_left         = (hs && x_odd) ? r_held : '0;
    end

    // pair sums, vertical add and rounded shift
    always_comb begin
        logic [PAIR_BITS-1:0] pair;
        logic [PAIR_BITS-1:0] line;
        logic [SUM_BITS-1:0]  sum;
        logic [SUM_BITS:0]    rnd;
        logic [SUM_BITS:0]    shifted;
        s1_pair_packed = '0;
        s1_result      = '0;
        line_data      = r_s1_ctl.fwd ? r_fwd_data : line_rdata;
        for (int c = 0; c < NCH; c++) begin
            pair = PAIR_BITS'(r_s1_left[c*CB +: CB]) + PAIR_BITS'(r_s1_pix[c*CB +: CB]);
            line = r_s1_ctl.use_line ? line_data[c*PAIR_BITS +: PAIR_BITS] : '0;
            sum  = SUM_BITS'(pair) + SUM_BITS'(line);
            case (r_s1_ctl.shift)
                2'd1:    rnd = (SUM_BITS+1)'(sum) + (SUM_BITS+1)'(1);
                2'd2:    rnd = (SUM_BITS+1)'(sum) + (SUM_BITS+1)'(2);
                default: rnd = (SUM_BITS+1)'(sum);
            endcase
            shifted = rnd >> r_s1_ctl.shift;
            s1_pair_packed[c*PAIR_BITS +: PAIR_BITS] = pair;
            s1_result[c*CB +: CB] = shifted[CB-1:0];
        end
    end

    assign line_we = r_s1_valid && s1_advance && r_s1_ctl.write;

    mbds_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_s1_idx),
        .i_wdata (s1_pair_packed),
        .i_re    (accept),
        .i_raddr (n_idx),
        .o_rdata (line_rdata)
    );

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(W_RESET);
            r_height <= HW'(H_RESET);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == mbds_pkg::CFG_SOURCE_WIDTH) begin
                r_width <= n_width;
            end
            if (i_cfg_addr == mbds_pkg::CFG_SOURCE_HEIGHT) begin
                r_height <= n_height;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (x_last) begin
                r_col <= '0;
                r_row <= y_last ? '0 : r_row + YW'(1);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (accept && hs && !x_odd && !x_last) begin
            r_held <= i_s_axis_tdata[PIX_BITS-1:0];
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_ctl   <= '0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_s1_ctl   <= n_ctl;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
            r_s1_ctl   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= i_s_axis_tdata[PIX_BITS-1:0];
            r_s1_left  <= n_left;
            r_s1_idx   <= n_idx;
            r_fwd_data <= s1_pair_packed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_s1_valid && s1_advance && r_s1_ctl.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_advance && r_s1_ctl.emit) begin
            r_o_pix  <= s1_result;
            r_o_last <= r_s1_ctl.last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = DATA_BITS'(r_o_pix);
    assign o_m_axis_tlast  = r_o_last;

    // checks
    `MBDS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_o_valid && !i_m_axis_tready, r_o_valid)
    `MBDS_ASSERT_NOW(a_write_or_emit, i_clk, i_rst_n, r_s1_valid, !(r_s1_ctl.write && r_s1_ctl.emit))
    `MBDS_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, i_cfg_we, r_col == '0 && r_row == '0)
    `MBDS_ASSERT_NEXT(a_stage_stall, i_clk, i_rst_n, r_s1_valid && !s1_advance, r_s1_valid && $stable(r_s1_pix))

endmodule
